FILE: hdl/ps2dl_pkg.sv
// Shared constants, types and framing functions for the PS/2 device link layer.
`default_nettype none
package ps2dl_pkg;
   localparam int BQ_DEPTH  = 9;
   localparam int PQ_DEPTH  = 16;
   localparam int BQ_IDX_W  = $clog2(BQ_DEPTH);
   localparam int BCNT_W    = $clog2(BQ_DEPTH + 1);
   localparam int PQ_IDX_W  = $clog2(PQ_DEPTH);
   localparam int PCNT_W    = $clog2(PQ_DEPTH + 1);
   localparam int MEM_DEPTH = BQ_DEPTH * PQ_DEPTH;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam logic       CMD_PUSH    = 1'b0;
   localparam logic       CMD_POLL    = 1'b1;
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_RX     = 2'd1;
   localparam logic [1:0] KIND_DRAIN  = 2'd2;
   localparam logic [7:0] RESEND_BYTE = 8'hFE;
   localparam logic [10:0] FRAME_MASK = 11'h7FF;

   typedef struct packed {
      logic push;
      logic copy_wr;
      logic copy_done;
      logic tx_rd;
      logic retire;
      logic emit_tx;
      logic emit_drain;
      logic emit_rx;
      logic last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cmd_poll;
      logic bcnt_nz;
      logic copy_last;
      logic pkt_ready;
      logic pkt_done;
      logic out_free;
      logic host_abort;
      logic rx_valid;
   } dp_stat_type;

   function automatic logic odd_parity(input logic [7:0] b);
      odd_parity = ~(^b);
   endfunction

   function automatic logic [10:0] make_frame(input logic [7:0] b);
      make_frame = {1'b1, odd_parity(b), b, 1'b0} ^ FRAME_MASK;
   endfunction
endpackage
`default_nettype wire

FILE: hdl/ps2dl_ctrl.sv
// Sequencer for push, packet build, transmit, abort and receive handling.
`default_nettype none
module ps2dl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire ps2dl_pkg::dp_stat_type stat,
   output ps2dl_pkg::ctrl_cmd_type     cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_COPY, ST_TX, ST_READ, ST_ABORT, ST_RX
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (stat.cmd_poll) begin
                  state_in = stat.bcnt_nz ? ST_COPY : ST_TX;
               end else begin
                  cmd.push = 1'b1;
               end
            end
         end
         ST_COPY: begin
            cmd.copy_wr = 1'b1;
            if (stat.copy_last) begin
               cmd.copy_done = 1'b1;
               state_in      = ST_TX;
            end
         end
         ST_TX: begin
            if (stat.pkt_ready) begin
               if (stat.pkt_done) begin
                  cmd.retire = 1'b1;
                  state_in   = ST_ABORT;
               end else begin
                  cmd.tx_rd = 1'b1;
                  state_in  = ST_READ;
               end
            end else begin
               state_in = ST_ABORT;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               cmd.emit_tx = 1'b1;
               cmd.last    = !(stat.host_abort || stat.rx_valid);
               state_in    = ST_ABORT;
            end
         end
         ST_ABORT: begin
            if (!stat.host_abort) begin
               state_in = ST_RX;
            end else if (stat.out_free) begin
               cmd.emit_drain = 1'b1;
               cmd.last       = !stat.rx_valid;
               state_in       = ST_RX;
            end
         end
         ST_RX: begin
            if (!stat.rx_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_rx = 1'b1;
               cmd.last    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/ps2dl_dpath.sv
// Byte queue, packet store, pointers, framing and output register.
`default_nettype none
module ps2dl_dpath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic [23:0]             req_tdata,
   input  wire logic                    req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [31:0]                  rsp_tdata,
   output logic [1:0]                   rsp_tuser,
   output logic                         rsp_tlast,
   input  wire ps2dl_pkg::ctrl_cmd_type cmd,
   output ps2dl_pkg::dp_stat_type       stat
);
   localparam int BQD = ps2dl_pkg::BQ_DEPTH;
   localparam int PQD = ps2dl_pkg::PQ_DEPTH;
   localparam int AW  = ps2dl_pkg::MEM_AW;

   logic load;
   logic line_idle_ff, tx_empty_ff, host_abort_ff, rx_valid_ff;
   logic [8:0] rx_frame_ff;

   logic [7:0] bq_ff [BQD];
   logic [ps2dl_pkg::BCNT_W-1:0] bcnt_ff, k_ff;
   logic [7:0] mem [ps2dl_pkg::MEM_DEPTH];
   logic [7:0] rdata_ff;
   logic [ps2dl_pkg::BCNT_W-1:0] plen_ff [PQD];
   logic [ps2dl_pkg::PQ_IDX_W-1:0] head_ff, tail_ff;
   logic [ps2dl_pkg::PCNT_W-1:0] pcnt_ff;
   logic [ps2dl_pkg::BCNT_W-1:0] sent_ff;
   logic [7:0] last_sent_ff, last_rx_ff;

   logic rsp_valid_ff, last_ff;
   logic [1:0] kind_ff;
   logic [10:0] frame_ff;
   logic [7:0] rxb_ff, prev_ff;

   logic pq_full, rx_bad, rx_resend;
   logic [7:0] rx_data;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [ps2dl_pkg::PQ_IDX_W-1:0] head_nx, tail_nx;

   assign load     = req_tvalid && req_tready;
   assign pq_full  = (pcnt_ff == ps2dl_pkg::PCNT_W'(PQD));
   assign rx_data  = rx_frame_ff[7:0];
   assign rx_bad   = ps2dl_pkg::odd_parity(rx_data) != rx_frame_ff[8];
   assign rx_resend = (rx_frame_ff == {1'b0, ps2dl_pkg::RESEND_BYTE});
   assign wr_addr  = AW'(tail_ff) * AW'(BQD) + AW'(k_ff);
   assign rd_addr  = AW'(head_ff) * AW'(BQD) + AW'(sent_ff);
   assign head_nx  = (head_ff == ps2dl_pkg::PQ_IDX_W'(PQD - 1)) ? '0 : head_ff + 1'b1;
   assign tail_nx  = (tail_ff == ps2dl_pkg::PQ_IDX_W'(PQD - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      stat            = '0;
      stat.cmd_poll   = (req_tuser == ps2dl_pkg::CMD_POLL);
      stat.bcnt_nz    = (bcnt_ff != '0);
      stat.copy_last  = (k_ff == bcnt_ff - 1'b1);
      stat.pkt_ready  = (pcnt_ff != '0) && tx_empty_ff && line_idle_ff;
      stat.pkt_done   = (sent_ff >= plen_ff[head_ff]);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      stat.host_abort = host_abort_ff;
      stat.rx_valid   = rx_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         line_idle_ff  <= req_tdata[8];
         tx_empty_ff   <= req_tdata[9];
         host_abort_ff <= req_tdata[10];
         rx_valid_ff   <= req_tdata[11];
         rx_frame_ff   <= req_tdata[20:12];
      end
      if (cmd.push && bcnt_ff < ps2dl_pkg::BCNT_W'(BQD)) begin
         bq_ff[bcnt_ff[ps2dl_pkg::BQ_IDX_W-1:0]] <= req_tdata[7:0];
      end
      if (cmd.copy_wr && !pq_full) begin
         mem[wr_addr] <= bq_ff[k_ff[ps2dl_pkg::BQ_IDX_W-1:0]];
      end
      if (cmd.tx_rd) begin
         rdata_ff <= mem[rd_addr];
      end
      if (cmd.copy_done && !pq_full) begin
         plen_ff[tail_ff] <= bcnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff      <= '0;
         k_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         pcnt_ff      <= '0;
         sent_ff      <= '0;
         last_sent_ff <= '0;
         last_rx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.push && bcnt_ff < ps2dl_pkg::BCNT_W'(BQD)) begin
            bcnt_ff <= bcnt_ff + 1'b1;
         end
         if (cmd.copy_wr) begin
            k_ff <= k_ff + 1'b1;
         end
         if (cmd.copy_done) begin
            k_ff    <= '0;
            bcnt_ff <= '0;
            if (!pq_full) begin
               tail_ff <= tail_nx;
               pcnt_ff <= pcnt_ff + 1'b1;
            end
         end
         if (cmd.retire) begin
            sent_ff <= '0;
            head_ff <= head_nx;
            pcnt_ff <= pcnt_ff - 1'b1;
         end
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.emit_tx) begin
            sent_ff      <= sent_ff + 1'b1;
            last_sent_ff <= rdata_ff;
            rsp_valid_ff <= 1'b1;
            kind_ff      <= ps2dl_pkg::KIND_TX;
            frame_ff     <= ps2dl_pkg::make_frame(rdata_ff);
            rxb_ff       <= '0;
            prev_ff      <= '0;
            last_ff      <= cmd.last;
         end
         if (cmd.emit_drain) begin
            sent_ff      <= '0;
            rsp_valid_ff <= 1'b1;
            kind_ff      <= ps2dl_pkg::KIND_DRAIN;
            frame_ff     <= '0;
            rxb_ff       <= '0;
            prev_ff      <= '0;
            last_ff      <= cmd.last;
         end
         if (cmd.emit_rx) begin
            rsp_valid_ff <= 1'b1;
            last_ff      <= cmd.last;
            if (rx_bad) begin
               kind_ff  <= ps2dl_pkg::KIND_TX;
               frame_ff <= ps2dl_pkg::make_frame(ps2dl_pkg::RESEND_BYTE);
               rxb_ff   <= '0;
               prev_ff  <= '0;
            end else if (rx_resend) begin
               kind_ff  <= ps2dl_pkg::KIND_TX;
               frame_ff <= ps2dl_pkg::make_frame(last_sent_ff);
               rxb_ff   <= '0;
               prev_ff  <= '0;
            end else begin
               kind_ff    <= ps2dl_pkg::KIND_RX;
               frame_ff   <= '0;
               rxb_ff     <= rx_data;
               prev_ff    <= last_rx_ff;
               last_rx_ff <= rx_data;
               bcnt_ff    <= '0;
               head_ff    <= '0;
               tail_ff    <= '0;
               pcnt_ff    <= '0;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, prev_ff, rxb_ff, frame_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_pcnt_range: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= ps2dl_pkg::PCNT_W'(PQD))
      else $error("packet count beyond queue depth");
   a_bcnt_range: assert property (@(posedge clock) disable iff (reset)
      bcnt_ff <= ps2dl_pkg::BCNT_W'(BQD))
      else $error("byte count beyond queue depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(cmd.emit_tx || cmd.emit_drain || cmd.emit_rx))
      else $error("result overwritten before transfer");
   a_sent_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.tx_rd |-> (sent_ff < ps2dl_pkg::BCNT_W'(BQD)))
      else $error("read beyond packet slot");
endmodule
`default_nettype wire

FILE: hdl/ps2_device_link_layer.sv
// PS/2 device link layer: a push transfer is handled in the sequencer's idle
// state and returns no result. A poll moves each queued byte into the packet
// store (packet copy runs one byte per cycle over the single write port) and
// reads the packet store when a frame is sent; each result then waits for the
// output register to be free.
// A poll emits up to three results; tlast marks the final one.
`default_nettype none
module ps2_device_link_layer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] byte_in, [8] line_idle, [9] tx_empty, [10] host_abort,
   // [11] rx_valid, [20:12] rx_frame
   input  wire logic [23:0] req_tdata,
   // [0] command
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [10:0] tx_frame, [18:11] rx_byte, [26:19] prev_rx_byte
   output logic [31:0]      rsp_tdata,
   // [1:0] kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);
   ps2dl_pkg::ctrl_cmd_type cmd;
   ps2dl_pkg::dp_stat_type  stat;

   ps2dl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ps2dl_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );
endmodule
`default_nettype wire

FILE: dv/tb_ps2_device_link_layer.sv
// Testbench for the PS/2 device link layer: directed table plus random pushes and polls, checked by a predictor.
`default_nettype none
module tb_ps2_device_link_layer;
   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] tx_frame;
      logic [7:0]  rx_byte;
      logic [7:0]  prev_rx_byte;
      logic        last;
   } link_result_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  byte_in;
      logic        line_idle;
      logic        tx_empty;
      logic        host_abort;
      logic        rx_valid;
      logic [8:0]  rx_frame;
      logic        has_exp;
      logic [1:0]  exp_kind;
      logic [10:0] exp_frame;
   } link_row_type;

   localparam int IDLE_LIMIT = 5000;
   localparam int BQD = ps2dl_pkg::BQ_DEPTH;
   localparam int PQD = ps2dl_pkg::PQ_DEPTH;
   localparam logic PUSH = ps2dl_pkg::CMD_PUSH;
   localparam logic POLL = ps2dl_pkg::CMD_POLL;
   localparam logic [1:0] KTX = ps2dl_pkg::KIND_TX;
   localparam logic [1:0] KRX = ps2dl_pkg::KIND_RX;
   localparam logic [1:0] KDR = ps2dl_pkg::KIND_DRAIN;
   localparam logic [7:0] RESEND = ps2dl_pkg::RESEND_BYTE;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   ps2_device_link_layer dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [7:0] bq [BQD];
   int         bcnt = 0;
   logic [7:0] pbytes [PQD][BQD];
   int         plen [PQD];
   int         phead = 0, ptail = 0, pcnt = 0, sent = 0;
   logic [7:0] last_tx = '0, last_rx = '0;

   link_result_type expected_results[$];
   int              errors = 0;
   int              idle_cycles = 0;

   function automatic logic [10:0] frame_of(input logic [7:0] b);
      logic p;
      p = ~(^b);
      return {1'b1, p, b, 1'b0} ^ ps2dl_pkg::FRAME_MASK;
   endfunction

   task automatic predict_link(input logic cmd, input logic [7:0] b, input logic li,
                               input logic te, input logic ab, input logic rv,
                               input logic [8:0] rf);
      link_result_type r;
      int              first;
      first = expected_results.size();
      if (cmd == PUSH) begin
         if (bcnt < BQD) begin
            bq[bcnt] = b;
            bcnt++;
         end
         return;
      end
      if (bcnt > 0) begin
         if (pcnt < PQD) begin
            for (int k = 0; k < bcnt; k++) pbytes[ptail][k] = bq[k];
            plen[ptail] = bcnt;
            ptail = (ptail + 1) % PQD;
            pcnt++;
         end
         bcnt = 0;
      end
      if (pcnt > 0 && te && li) begin
         if (sent >= plen[phead]) begin
            sent = 0;
            phead = (phead + 1) % PQD;
            pcnt--;
         end else begin
            last_tx = pbytes[phead][sent];
            sent++;
            r = '{KTX, frame_of(last_tx), 8'd0, 8'd0, 1'b0};
            expected_results.push_back(r);
         end
      end
      if (ab) begin
         sent = 0;
         r = '{KDR, 11'd0, 8'd0, 8'd0, 1'b0};
         expected_results.push_back(r);
      end
      if (rv) begin
         if (~(^rf[7:0]) != rf[8])
            r = '{KTX, frame_of(RESEND), 8'd0, 8'd0, 1'b0};
         else if (rf == {1'b0, RESEND})
            r = '{KTX, frame_of(last_tx), 8'd0, 8'd0, 1'b0};
         else begin
            bcnt = 0; phead = 0; ptail = 0; pcnt = 0;
            r = '{KRX, 11'd0, rf[7:0], last_rx, 1'b0};
            last_rx = rf[7:0];
         end
         expected_results.push_back(r);
      end
      if (expected_results.size() > first)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endtask

   // sender: bursts with gaps
   int burst_left = 0;
   int gap_left = 0;

   task automatic send_item(input logic cmd, input logic [7:0] b, input logic li,
                            input logic te, input logic ab, input logic rv,
                            input logic [8:0] rf);
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      predict_link(cmd, b, li, te, ab, rv, rf);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'd0, rf, rv, ab, te, li, b};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 12);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) req_tvalid <= 1'b0;
   endtask

   task automatic wait_results;
      while (expected_results.size() > 0) @(posedge clock);
   endtask

   // stop sending until every expected result has come
   task automatic pause_sender;
      if (gap_left == 0) req_tvalid <= 1'b0;
      gap_left = 0;
      @(posedge clock);
      wait_results();
   endtask

   // receiver stall pattern
   int stall_mode = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected transfer kind=%0d", rsp_tuser);
            errors++;
         end else begin
            link_result_type e;
            e = expected_results.pop_front();
            if (rsp_tuser != e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_tuser); errors++;
            end
            if (rsp_tdata[10:0] != e.tx_frame) begin
               $error("tx_frame exp %h got %h", e.tx_frame, rsp_tdata[10:0]); errors++;
            end
            if (rsp_tdata[18:11] != e.rx_byte) begin
               $error("rx_byte exp %h got %h", e.rx_byte, rsp_tdata[18:11]); errors++;
            end
            if (rsp_tdata[26:19] != e.prev_rx_byte) begin
               $error("prev_rx_byte exp %h got %h", e.prev_rx_byte, rsp_tdata[26:19]);
               errors++;
            end
            if (rsp_tlast != e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_tlast); errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_ps2_device_link_layer NOT OK");
         $finish;
      end
   end

   function automatic logic [8:0] good_frame(input logic [7:0] d);
      return {~(^d), d};
   endfunction

   // directed rows; has_exp rows carry a typed-in single result
   link_row_type dir_rows [14] = '{
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 9'h0FE, 1'b1, KTX, 11'h1FF},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 9'h000, 1'b1, KDR, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 9'h000, 1'b1, KTX, 11'h203},
      '{PUSH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 9'h1FF, 1'b0, KTX, 11'h000},
      '{PUSH, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000, 1'b1, KTX, 11'h1FF},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 9'h000, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 9'h000, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 9'h1FE, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 9'h155, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 9'h0FF, 1'b0, KTX, 11'h000},
      '{POLL, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 9'h100, 1'b0, KTX, 11'h000}
   };

   initial begin
      logic [7:0] d;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) begin
         link_row_type t;
         t = dir_rows[i];
         if (t.has_exp) begin
            pause_sender();
            send_item(t.cmd, t.byte_in, t.line_idle, t.tx_empty, t.host_abort,
                      t.rx_valid, t.rx_frame);
            if (expected_results.size() != 1 || expected_results[0].kind != t.exp_kind ||
                expected_results[0].tx_frame != t.exp_frame) begin
               $error("row %0d table kind %0d frame %h disagrees with predictor",
                      i, t.exp_kind, t.exp_frame);
               errors++;
            end
         end else
            send_item(t.cmd, t.byte_in, t.line_idle, t.tx_empty, t.host_abort,
                      t.rx_valid, t.rx_frame);
      end
      // overflow byte queue, then packet queue
      for (int i = 0; i < 11; i++)
         send_item(PUSH, 8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, 9'h000);
      for (int p = 0; p < 18; p++) begin
         send_item(PUSH, 8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, 9'h000);
         send_item(POLL, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 9'h000);
      end
      pause_sender();
      // random traffic: mostly packet sequences with noise
      for (int it = 0; it < 180; it++) begin
         int sel;
         sel = $urandom_range(0, 99);
         if (sel < 35)
            send_item(PUSH, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom), 9'($urandom));
         else begin
            logic rv;
            logic [8:0] rf;
            d = 8'($urandom);
            rv = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
               0: rf = {1'b0, RESEND};
               1: rf = 9'($urandom);
               default: rf = good_frame(d);
            endcase
            send_item(POLL, 8'($urandom), ($urandom_range(0, 5) != 0),
                      ($urandom_range(0, 5) != 0), ($urandom_range(0, 14) == 0), rv, rf);
         end
         if (it == 120) pause_sender();
      end
      pause_sender();
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("tb_ps2_device_link_layer OK");
      else
         $display("tb_ps2_device_link_layer NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
